// ===== rtl/dtr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtr_pkg
// Types, command codes and helper functions shared by the divider/timer.
// ----------------------------------------------------------------------------
package dtr_pkg;

    typedef enum logic [2:0] {
        CMD_ADVANCE     = 3'd0,
        CMD_READ_DIV    = 3'd1,
        CMD_READ_TIMER  = 3'd2,
        CMD_WRITE_DIV   = 3'd3,
        CMD_WRITE_TIMER = 3'd4,
        CMD_WRITE_MOD   = 3'd5,
        CMD_WRITE_CTRL  = 3'd6
    } t_cmd;

    localparam int unsigned CTRL_EN = 2;

    localparam logic [1:0] SEL_BIT9 = 2'd0;
    localparam logic [1:0] SEL_BIT3 = 2'd1;
    localparam logic [1:0] SEL_BIT5 = 2'd2;
    localparam logic [1:0] SEL_BIT7 = 2'd3;

    typedef struct packed {
        logic [15:0] div;
        logic [7:0]  tima;
        logic [7:0]  tma;
        logic [2:0]  tac;
    } t_state;

    typedef struct packed {
        logic [7:0] value;
        logic       ovf;
    } t_tick;

    // Falling edges of the selected bit from one count to another, low 8 bits.
    function automatic logic [7:0] edge_ticks(
        input logic [15:0] from_cnt,
        input logic [15:0] to_cnt,
        input logic [1:0]  sel
    );
        logic [5:0] d9;
        logic [7:0] res;
        d9 = to_cnt[15:10] - from_cnt[15:10];
        unique case (sel)
            SEL_BIT9: res = {2'b00, d9};
            SEL_BIT3: res = to_cnt[11:4] - from_cnt[11:4];
            SEL_BIT5: res = to_cnt[13:6] - from_cnt[13:6];
            SEL_BIT7: res = to_cnt[15:8] - from_cnt[15:8];
            default:  res = '0;
        endcase
        return res;
    endfunction

    function automatic logic sel_tap(
        input logic [15:0] cnt,
        input logic [1:0]  sel
    );
        logic res;
        unique case (sel)
            SEL_BIT9: res = cnt[9];
            SEL_BIT3: res = cnt[3];
            SEL_BIT5: res = cnt[5];
            SEL_BIT7: res = cnt[7];
            default:  res = 1'b0;
        endcase
        return res;
    endfunction

    // Add ticks, reload with the modulo on wrap.
    function automatic t_tick add_ticks(
        input logic [7:0] t,
        input logic [7:0] ticks,
        input logic [7:0] modulo
    );
        logic [7:0] n;
        t_tick      res;
        n         = t + ticks;
        res.ovf   = (t > n);
        res.value = res.ovf ? n + modulo : n;
        return res;
    endfunction

endpackage

// ===== rtl/dtr_step.sv =====
// ----------------------------------------------------------------------------
// dtr_step
// Next state and result for one request, from the current timer state.
// ----------------------------------------------------------------------------
module dtr_step (
    input  dtr_pkg::t_state i_state,
    input  logic [2:0]      i_command,
    input  logic [7:0]      i_cycles,
    input  logic [7:0]      i_write_value,
    output dtr_pkg::t_state o_state,
    output logic [7:0]      o_read_data,
    output logic            o_timer_interrupt
);
    import dtr_pkg::*;

    logic [15:0] div_adv;
    logic        en;
    t_tick       adv;
    t_tick       extra;

    assign div_adv = i_state.div + {8'b0, i_cycles};
    assign en      = i_state.tac[CTRL_EN];
    assign adv     = add_ticks(i_state.tima,
                               edge_ticks(i_state.div, div_adv, i_state.tac[1:0]),
                               i_state.tma);
    assign extra   = add_ticks(adv.value, {7'b0, sel_tap(div_adv, i_state.tac[1:0])},
                               i_state.tma);

    always_comb begin
        o_state           = i_state;
        o_read_data       = '0;
        o_timer_interrupt = 1'b0;
        unique case (i_command)
            CMD_READ_DIV: begin
                o_read_data = div_adv[15:8];
            end
            CMD_READ_TIMER: begin
                o_read_data = en ? adv.value : i_state.tima;
            end
            CMD_WRITE_DIV: begin
                o_state.div       = '0;
                o_state.tima      = en ? extra.value : i_state.tima;
                o_timer_interrupt = en && (adv.ovf || extra.ovf);
            end
            CMD_ADVANCE, CMD_WRITE_TIMER, CMD_WRITE_MOD, CMD_WRITE_CTRL: begin
                o_state.div       = div_adv;
                o_state.tima      = en ? adv.value : i_state.tima;
                o_timer_interrupt = en && adv.ovf;
                if (i_command == CMD_WRITE_TIMER) begin
                    o_state.tima = i_write_value;
                end
                if (i_command == CMD_WRITE_MOD) begin
                    o_state.tma = i_write_value;
                end
                if (i_command == CMD_WRITE_CTRL) begin
                    o_state.tac = i_write_value[2:0];
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ===== rtl/divider_timer_with_reload_top.sv =====
// ----------------------------------------------------------------------------
// divider_timer_with_reload_top
// 16-bit divider with an 8-bit reloading timer, one request per cycle while unstalled.
// ----------------------------------------------------------------------------
// A request passes through the input register, then the result register.
// Throughput: 1 request per cycle while the result side does not stall; the
// timer state update for a request completes in the same cycle it moves to
// the result register.
// Reset: synchronous, active low; clears the divider, timer, modulo,
// control and all valid flags.
module divider_timer_with_reload_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_command,
    input  logic [7:0] i_cycles,
    input  logic [7:0] i_write_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_timer_interrupt
);
    import dtr_pkg::*;

    logic       r_in_valid;
    logic [2:0] r_command;
    logic [7:0] r_cycles;
    logic [7:0] r_write_value;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic [7:0] r_read_data;
    logic       r_irq;
    logic [7:0] n_read_data;
    logic       n_irq;
    logic       out_free;
    logic       move;
    logic       in_take;

    assign out_free = !r_out_valid || !i_stall;
    assign move     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    dtr_step u_step (
        .i_state           (r_state),
        .i_command         (r_command),
        .i_cycles          (r_cycles),
        .i_write_value     (r_write_value),
        .o_state           (n_state),
        .o_read_data       (n_read_data),
        .o_timer_interrupt (n_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command     <= i_command;
            r_cycles      <= i_cycles;
            r_write_value <= i_write_value;
        end
        if (move) begin
            r_read_data <= n_read_data;
            r_irq       <= n_irq;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_read_data       = r_read_data;
    assign o_timer_interrupt = r_irq;

endmodule

// ===== rtl/dtr_checker.sv =====
// ----------------------------------------------------------------------------
// dtr_checker
// Port-level checks for the divider/timer, bound to the top level.
// ----------------------------------------------------------------------------
module dtr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_read_data,
    input logic       o_timer_interrupt
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result side is free");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without a request two cycles earlier");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_data)
                                  && $stable(o_timer_interrupt)))
        else $error("stalled result changed");

endmodule

bind divider_timer_with_reload_top dtr_checker u_dtr_checker (.*);
